/* sv/bb3_pkg.sv */
// Package for the 3x3 RGBA box blur: payload types, divider constants and control codes.
// Used by the mean unit, the top level and the testbench; depends on nothing.
`default_nettype none
package bb3_pkg;

    localparam int LANES       = 4;
    localparam int LANE_W      = 8;
    localparam int PIX_W       = 32;
    localparam int SUM_W       = 12;
    localparam int TAG_W       = 12;
    localparam int SIDE_W      = 13;
    localparam int GRID_N      = 9;
    localparam int WIN_N       = 6;
    localparam int DEF_SIDE    = 1024;

    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_4 = 15'd16384;
    localparam logic [RECIP_W-1:0] RECIP_6 = 15'd10923;
    localparam logic [RECIP_W-1:0] RECIP_9 = 15'd7282;

    localparam int N_TASKS      = 4;
    localparam int TASK_UP_LEFT = 0;
    localparam int TASK_UP      = 1;
    localparam int TASK_LEFT    = 2;
    localparam int TASK_HERE    = 3;

    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [SIDE_W-1:0] side_t;

    typedef struct packed {
        pixel_t pixel_in;
    } pix_item_t;

    typedef struct packed {
        logic [TAG_W-1:0] out_row;
        logic [TAG_W-1:0] out_col;
        pixel_t           pixel_out;
        logic             frame_done;
    } res_item_t;

    typedef logic [GRID_N-1:0][PIX_W-1:0] grid_t;
    typedef logic [LANES-1:0][SUM_W-1:0]  lane_sum_t;

    typedef enum logic [1:0] {
        DIV_BY_4,
        DIV_BY_6,
        DIV_BY_9
    } div_t;

    typedef struct packed {
        logic             start;
        logic             use_top;
        logic             use_left;
        logic [TAG_W-1:0] row;
        logic [TAG_W-1:0] col;
        logic             last;
    } mean_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } state_t;

    function automatic logic [RECIP_W-1:0] recip_of(input div_t code);
        logic [RECIP_W-1:0] r;
        unique case (code)
            DIV_BY_4: r = RECIP_4;
            DIV_BY_6: r = RECIP_6;
            DIV_BY_9: r = RECIP_9;
            default:  r = RECIP_4;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/bb3_stream_if.sv */
// Valid/ready channel with a typed payload, used for pixels, results and configuration.
// Payload types come from bb3_pkg at the point of instantiation.
`default_nettype none
interface bb3_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/bb3_line_ram.sv */
// Simple dual-port line memory with registered read.
// Generic; no package dependency.
`default_nettype none
module bb3_line_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data,
    input  wire logic                                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule
`default_nettype wire

/* sv/bb3_mean_unit.sv */
// Two-stage mean unit: masked lane sums of the 3x3 grid, then reciprocal divide by 4, 6 or 9.
// Depends on bb3_pkg for the request, grid and result types.
`default_nettype none
module bb3_mean_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bb3_pkg::mean_req_t req,
    input  wire bb3_pkg::grid_t     grid,
    output bb3_pkg::res_item_t      res,
    output logic                    res_valid
);

    localparam int PROD_W = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;

    bb3_pkg::lane_sum_t sum_next;
    bb3_pkg::lane_sum_t sum_reg;
    bb3_pkg::div_t      div_next;
    bb3_pkg::div_t      div_reg;
    logic [bb3_pkg::TAG_W-1:0] row_reg;
    logic [bb3_pkg::TAG_W-1:0] col_reg;
    logic               last_reg;
    logic               s1_valid_reg;
    logic               res_valid_reg;
    bb3_pkg::pixel_t    pix_next;
    bb3_pkg::res_item_t res_reg;
    logic [PROD_W-1:0]  prod [bb3_pkg::LANES];

    always_comb
    begin
        logic use_slot;
        int   s;
        sum_next = '0;
        for (int xs = 0; xs < 3; xs++)
        begin
            for (int ys = 0; ys < 3; ys++)
            begin
                s = xs * 3 + ys;
                use_slot = (xs != 0 || req.use_left) && (ys != 0 || req.use_top);
                for (int k = 0; k < bb3_pkg::LANES; k++)
                begin
                    sum_next[k] = sum_next[k] + (use_slot ?
                        bb3_pkg::SUM_W'(grid[s][k*bb3_pkg::LANE_W +: bb3_pkg::LANE_W]) :
                        bb3_pkg::SUM_W'(0));
                end
            end
        end
        case ({req.use_top, req.use_left})
            2'b11:   div_next = bb3_pkg::DIV_BY_9;
            2'b00:   div_next = bb3_pkg::DIV_BY_4;
            default: div_next = bb3_pkg::DIV_BY_6;
        endcase
    end

    always_comb
    begin
        logic [bb3_pkg::RECIP_W-1:0] recip;
        recip = bb3_pkg::recip_of(div_reg);
        for (int k = 0; k < bb3_pkg::LANES; k++)
        begin
            prod[k] = PROD_W'(sum_reg[k]) * PROD_W'(recip);
            pix_next[k*bb3_pkg::LANE_W +: bb3_pkg::LANE_W] =
                prod[k][bb3_pkg::RECIP_SHIFT +: bb3_pkg::LANE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= req.start;
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            sum_reg  <= sum_next;
            div_reg  <= div_next;
            row_reg  <= req.row;
            col_reg  <= req.col;
            last_reg <= req.last;
        end
        if (s1_valid_reg)
        begin
            res_reg.out_row    <= row_reg;
            res_reg.out_col    <= col_reg;
            res_reg.pixel_out  <= pix_next;
            res_reg.frame_done <= last_reg;
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule
`default_nettype wire

/* sv/box_blur_3x3_rgba_unit.sv */
// Top level of the 3x3 RGBA box blur: sequencer, window registers and line memories.
// Depends on bb3_pkg, bb3_stream_if, bb3_line_ram and bb3_mean_unit.
// Each pixel yields k results (0 to 4); the line memories are read when the pixel is accepted,
// then written back while the 3x3 grid is loaded, and each result is then issued in turn
// through the shared two-stage mean unit to the output register; the next pixel waits for all.
// Reset clears the counters and the window and sets the side to 1024; memories are not cleared.
`default_nettype none
module box_blur_3x3_rgba_unit #(
    parameter int MAX_SIDE = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bb3_stream_if.sink       pixels,
    bb3_stream_if.source     results,
    bb3_stream_if.sink       cfg
);

    localparam int CNT_W      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_RESET = (bb3_pkg::DEF_SIDE > MAX_SIDE) ? MAX_SIDE : bb3_pkg::DEF_SIDE;
    localparam logic [CNT_W-1:0] LAST_RESET = CNT_W'(SIDE_RESET - 1);
    localparam logic [CNT_W-1:0] LAST_MAX   = CNT_W'(MAX_SIDE - 1);

    bb3_pkg::state_t    state_reg;
    bb3_pkg::state_t    state_next;
    logic [CNT_W-1:0]   row_reg;
    logic [CNT_W-1:0]   col_reg;
    logic [CNT_W-1:0]   cur_r_reg;
    logic [CNT_W-1:0]   cur_c_reg;
    logic [CNT_W-1:0]   last_reg;
    logic [CNT_W-1:0]   cfg_last;
    bb3_pkg::pixel_t    pix_reg;
    bb3_pkg::pixel_t    win_reg [bb3_pkg::WIN_N];
    bb3_pkg::grid_t     grid_reg;
    logic [bb3_pkg::N_TASKS-1:0] pend_reg;
    logic [bb3_pkg::N_TASKS-1:0] pend_next;
    logic [bb3_pkg::N_TASKS-1:0] task_mask;
    logic [bb3_pkg::N_TASKS-1:0] pick_bit;
    bb3_pkg::pixel_t    upper_rd;
    bb3_pkg::pixel_t    lower_rd;
    logic               rd_en;
    logic               wr_en;
    logic               in_xfer;
    logic               cfg_xfer;
    logic               r_nz;
    logic               c_nz;
    logic               r_ge2;
    logic               c_ge2;
    logic               lastr;
    logic               lastc;
    logic [CNT_W-1:0]   r_m1;
    logic [CNT_W-1:0]   c_m1;
    bb3_pkg::mean_req_t pick_req;
    bb3_pkg::mean_req_t req;
    bb3_pkg::res_item_t mean_res;
    logic               mean_valid;

    assign in_xfer   = pixels.valid && pixels.ready;
    assign cfg_xfer  = cfg.valid && cfg.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (32'(cfg.data) > 32'(MAX_SIDE))
        begin
            cfg_last = LAST_MAX;
        end
        else if (cfg.data < bb3_pkg::SIDE_W'(2))
        begin
            cfg_last = CNT_W'(1);
        end
        else
        begin
            cfg_last = CNT_W'(cfg.data - bb3_pkg::SIDE_W'(1));
        end
    end

    assign r_nz  = cur_r_reg != '0;
    assign c_nz  = cur_c_reg != '0;
    assign r_ge2 = cur_r_reg > CNT_W'(1);
    assign c_ge2 = cur_c_reg > CNT_W'(1);
    assign lastr = cur_r_reg == last_reg;
    assign lastc = cur_c_reg == last_reg;
    assign r_m1  = cur_r_reg - CNT_W'(1);
    assign c_m1  = cur_c_reg - CNT_W'(1);

    always_comb
    begin
        task_mask = '0;
        task_mask[bb3_pkg::TASK_UP_LEFT] = r_nz && c_nz;
        task_mask[bb3_pkg::TASK_UP]      = r_nz && lastc;
        task_mask[bb3_pkg::TASK_LEFT]    = lastr && c_nz;
        task_mask[bb3_pkg::TASK_HERE]    = lastr && lastc;
    end

    always_comb
    begin
        pick_bit       = '0;
        pick_req       = '0;
        pick_req.start = 1'b1;
        if (pend_reg[bb3_pkg::TASK_UP_LEFT])
        begin
            pick_bit[bb3_pkg::TASK_UP_LEFT] = 1'b1;
            pick_req.row      = bb3_pkg::TAG_W'(r_m1);
            pick_req.col      = bb3_pkg::TAG_W'(c_m1);
            pick_req.use_top  = r_ge2;
            pick_req.use_left = c_ge2;
        end
        else if (pend_reg[bb3_pkg::TASK_UP])
        begin
            pick_bit[bb3_pkg::TASK_UP] = 1'b1;
            pick_req.row      = bb3_pkg::TAG_W'(r_m1);
            pick_req.col      = bb3_pkg::TAG_W'(cur_c_reg);
            pick_req.use_top  = r_ge2;
        end
        else if (pend_reg[bb3_pkg::TASK_LEFT])
        begin
            pick_bit[bb3_pkg::TASK_LEFT] = 1'b1;
            pick_req.row      = bb3_pkg::TAG_W'(cur_r_reg);
            pick_req.col      = bb3_pkg::TAG_W'(c_m1);
            pick_req.use_left = c_ge2;
        end
        else
        begin
            pick_bit[bb3_pkg::TASK_HERE] = 1'b1;
            pick_req.row      = bb3_pkg::TAG_W'(cur_r_reg);
            pick_req.col      = bb3_pkg::TAG_W'(cur_c_reg);
            pick_req.last     = 1'b1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        pixels.ready  = 1'b0;
        results.valid = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        req           = '0;
        unique case (state_reg)
            bb3_pkg::ST_IDLE:
            begin
                pixels.ready = 1'b1;
                if (pixels.valid)
                begin
                    rd_en      = 1'b1;
                    state_next = bb3_pkg::ST_READ;
                end
            end
            bb3_pkg::ST_READ:
            begin
                wr_en      = 1'b1;
                pend_next  = task_mask;
                state_next = (task_mask != '0) ? bb3_pkg::ST_ISSUE : bb3_pkg::ST_IDLE;
            end
            bb3_pkg::ST_ISSUE:
            begin
                req        = pick_req;
                pend_next  = pend_reg & ~pick_bit;
                state_next = bb3_pkg::ST_WAIT;
            end
            bb3_pkg::ST_WAIT:
            begin
                if (mean_valid)
                begin
                    state_next = bb3_pkg::ST_OUT;
                end
            end
            bb3_pkg::ST_OUT:
            begin
                results.valid = 1'b1;
                if (results.ready)
                begin
                    state_next = (pend_reg != '0) ? bb3_pkg::ST_ISSUE : bb3_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bb3_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bb3_pkg::ST_IDLE;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            cur_r_reg <= '0;
            cur_c_reg <= '0;
            last_reg  <= LAST_RESET;
            for (int i = 0; i < bb3_pkg::WIN_N; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cfg_xfer)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            last_reg <= cfg_last;
            for (int i = 0; i < bb3_pkg::WIN_N; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (in_xfer)
        begin
            cur_r_reg <= row_reg;
            cur_c_reg <= col_reg;
            if (col_reg == last_reg)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == last_reg) ? '0 : row_reg + CNT_W'(1);
            end
            else
            begin
                col_reg <= col_reg + CNT_W'(1);
            end
        end
        else if (state_reg == bb3_pkg::ST_READ)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= upper_rd;
            win_reg[4] <= lower_rd;
            win_reg[5] <= pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pix_reg <= pixels.data.pixel_in;
        end
        if (state_reg == bb3_pkg::ST_READ)
        begin
            for (int i = 0; i < bb3_pkg::WIN_N; i++)
            begin
                grid_reg[i] <= win_reg[i];
            end
            grid_reg[6] <= upper_rd;
            grid_reg[7] <= lower_rd;
            grid_reg[8] <= pix_reg;
        end
    end

    bb3_line_ram #(
        .DEPTH (MAX_SIDE),
        .WIDTH (bb3_pkg::PIX_W)
    ) u_upper_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (col_reg),
        .rd_data (upper_rd),
        .wr_en   (wr_en),
        .wr_addr (cur_c_reg),
        .wr_data (lower_rd)
    );

    bb3_line_ram #(
        .DEPTH (MAX_SIDE),
        .WIDTH (bb3_pkg::PIX_W)
    ) u_lower_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (col_reg),
        .rd_data (lower_rd),
        .wr_en   (wr_en),
        .wr_addr (cur_c_reg),
        .wr_data (pix_reg)
    );

    bb3_mean_unit u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .grid      (grid_reg),
        .res       (mean_res),
        .res_valid (mean_valid)
    );

    assign results.data = mean_res;

endmodule
`default_nettype wire

/* sim/tb_box_blur_3x3_rgba_unit.sv */
// Testbench for box_blur_3x3_rgba_unit: directed rows, then random frames at random image sides.
// Each result is checked against a behavioral copy of the blur in this file or a typed value.
// Depends on bb3_pkg, bb3_stream_if and the RTL of the block.
`default_nettype none
module tb_box_blur_3x3_rgba_unit;

    localparam int SIDE_MAX     = 4096;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 24;
    localparam int MAX_REPORTS  = 10;
    localparam int RANDOM_ITEMS = 245;

    typedef enum logic {
        ROW_CFG,
        ROW_PIX
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [31:0]      value;
        logic             typed;
        bb3_pkg::pixel_t  want_pix;
    } dir_row_t;

    typedef bb3_pkg::pixel_t nbhd_t [3][3];

    localparam int DIR_ROWS = 28;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{ROW_PIX, 32'h12345678, 1'b0, 32'h0},
        '{ROW_PIX, 32'h9ABCDEF0, 1'b0, 32'h0},
        '{ROW_PIX, 32'h0F0F0F0F, 1'b0, 32'h0},
        '{ROW_CFG, 32'd2,        1'b0, 32'h0},
        '{ROW_PIX, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{ROW_PIX, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{ROW_PIX, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{ROW_PIX, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
        '{ROW_CFG, 32'd0,        1'b0, 32'h0},
        '{ROW_PIX, 32'h00000000, 1'b1, 32'h00000000},
        '{ROW_PIX, 32'h00000000, 1'b1, 32'h00000000},
        '{ROW_PIX, 32'h00000000, 1'b1, 32'h00000000},
        '{ROW_PIX, 32'h00000000, 1'b1, 32'h00000000},
        '{ROW_CFG, 32'd1,        1'b0, 32'h0},
        '{ROW_PIX, 32'hFF00FF00, 1'b0, 32'h0},
        '{ROW_PIX, 32'h00FF00FF, 1'b0, 32'h0},
        '{ROW_PIX, 32'h80808080, 1'b0, 32'h0},
        '{ROW_PIX, 32'h7F7F7F7F, 1'b0, 32'h0},
        '{ROW_CFG, 32'd3,        1'b0, 32'h0},
        '{ROW_PIX, 32'h01010101, 1'b0, 32'h0},
        '{ROW_PIX, 32'hFEFEFEFE, 1'b0, 32'h0},
        '{ROW_PIX, 32'h00000001, 1'b0, 32'h0},
        '{ROW_PIX, 32'h80000000, 1'b0, 32'h0},
        '{ROW_PIX, 32'hFFFFFFFF, 1'b0, 32'h0},
        '{ROW_PIX, 32'h00000000, 1'b0, 32'h0},
        '{ROW_PIX, 32'h55AA55AA, 1'b0, 32'h0},
        '{ROW_PIX, 32'hAA55AA55, 1'b0, 32'h0},
        '{ROW_PIX, 32'h7FFF8001, 1'b0, 32'h0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b0;

    bb3_stream_if #(.payload_t(bb3_pkg::pix_item_t)) pix_if ();
    bb3_stream_if #(.payload_t(bb3_pkg::res_item_t)) res_if ();
    bb3_stream_if #(.payload_t(bb3_pkg::side_t))     cfg_if ();

    assign res_if.ready = sink_ready;

    box_blur_3x3_rgba_unit #(.MAX_SIDE(SIDE_MAX)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_if),
        .results (res_if),
        .cfg     (cfg_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    bb3_pkg::pixel_t    upper_line [SIDE_MAX];
    bb3_pkg::pixel_t    lower_line [SIDE_MAX];
    bb3_pkg::pixel_t    win_px [6];
    int unsigned        row_cnt;
    int unsigned        col_cnt;
    bb3_pkg::side_t     side_reg;

    bb3_pkg::res_item_t blur_q [$];
    int          errors = 0;
    int          pixels_sent = 0;
    int          results_seen = 0;
    int          frames_seen = 0;
    int          cfg_writes = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          src_gaps_on = 1'b1;
    bit          sink_stalls_on = 1'b1;

    function automatic int pick_gap(input bit on);
        int roll;
        if (!on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int clamp_side(input bb3_pkg::side_t s);
        if (s < 2)
            return 2;
        if (s > SIDE_MAX)
            return SIDE_MAX;
        return s;
    endfunction

    function automatic bb3_pkg::pixel_t rand_pixel();
        bb3_pkg::pixel_t p;
        int k;
        p = $urandom;
        for (k = 0; k < bb3_pkg::LANES; k++)
        begin
            if ($urandom_range(0, 4) == 0)
                p[bb3_pkg::LANE_W*k +: bb3_pkg::LANE_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    function automatic bb3_pkg::pixel_t blur_mean(input nbhd_t g, input int r, input int c,
                                                  input int orow, input int ocol,
                                                  input int side);
        int rlo, rhi, clo, chi, ys, xs, n, y, x, k;
        int sum [bb3_pkg::LANES];
        bb3_pkg::pixel_t res;
        rlo = (orow == 0) ? 0 : orow - 1;
        rhi = (orow + 1 < side) ? orow + 1 : orow;
        clo = (ocol == 0) ? 0 : ocol - 1;
        chi = (ocol + 1 < side) ? ocol + 1 : ocol;
        n = 0;
        res = '0;
        for (k = 0; k < bb3_pkg::LANES; k++)
            sum[k] = 0;
        for (y = rlo; y <= rhi; y++)
        begin
            ys = y + 2 - r;
            if (ys >= 0 && ys <= 2)
            begin
                for (x = clo; x <= chi; x++)
                begin
                    xs = x + 2 - c;
                    if (xs >= 0 && xs <= 2)
                    begin
                        n++;
                        for (k = 0; k < bb3_pkg::LANES; k++)
                            sum[k] += g[xs][ys][bb3_pkg::LANE_W*k +: bb3_pkg::LANE_W];
                    end
                end
            end
        end
        if (n != 0)
        begin
            for (k = 0; k < bb3_pkg::LANES; k++)
                res[bb3_pkg::LANE_W*k +: bb3_pkg::LANE_W] = 8'(sum[k] / n);
        end
        return res;
    endfunction

    task automatic push_blur(input int r, input int c, input bb3_pkg::pixel_t pix,
                             input bit done);
        bb3_pkg::res_item_t e;
        e.out_row    = bb3_pkg::TAG_W'(r);
        e.out_col    = bb3_pkg::TAG_W'(c);
        e.pixel_out  = pix;
        e.frame_done = done;
        blur_q.push_back(e);
    endtask

    task automatic set_side(input bb3_pkg::side_t v);
        int k;
        side_reg = v;
        row_cnt = 0;
        col_cnt = 0;
        for (k = 0; k < 6; k++)
            win_px[k] = '0;
    endtask

    task automatic blur_step(input bb3_pkg::pixel_t p, input bit typed,
                             input bb3_pkg::pixel_t typed_pix);
        int side, r, c;
        nbhd_t g;
        bit lastc, lastr;
        side = clamp_side(side_reg);
        r = row_cnt;
        c = col_cnt;
        if (r >= side || c >= side)
        begin
            r = 0;
            c = 0;
        end
        g[0][0] = win_px[0];
        g[0][1] = win_px[1];
        g[0][2] = win_px[2];
        g[1][0] = win_px[3];
        g[1][1] = win_px[4];
        g[1][2] = win_px[5];
        g[2][0] = upper_line[c];
        g[2][1] = lower_line[c];
        g[2][2] = p;
        upper_line[c] = g[2][1];
        lower_line[c] = p;
        lastc = (c == side - 1);
        lastr = (r == side - 1);
        if (r >= 1)
        begin
            if (c >= 1)
                push_blur(r - 1, c - 1,
                          typed ? typed_pix : blur_mean(g, r, c, r - 1, c - 1, side), 1'b0);
            if (lastc)
                push_blur(r - 1, c,
                          typed ? typed_pix : blur_mean(g, r, c, r - 1, c, side), 1'b0);
        end
        if (lastr)
        begin
            if (c >= 1)
                push_blur(r, c - 1,
                          typed ? typed_pix : blur_mean(g, r, c, r, c - 1, side), 1'b0);
            if (lastc)
                push_blur(r, c, typed ? typed_pix : blur_mean(g, r, c, r, c, side), 1'b1);
        end
        win_px[0] = g[1][0];
        win_px[1] = g[1][1];
        win_px[2] = g[1][2];
        win_px[3] = g[2][0];
        win_px[4] = g[2][1];
        win_px[5] = g[2][2];
        c++;
        if (c >= side)
        begin
            c = 0;
            r++;
            if (r >= side)
                r = 0;
        end
        col_cnt = c;
        row_cnt = r;
    endtask

    task automatic send_pixel(input bb3_pkg::pixel_t p, input bit typed,
                              input bb3_pkg::pixel_t typed_pix);
        int gap;
        pix_if.valid <= 1'b1;
        pix_if.data  <= bb3_pkg::pix_item_t'(p);
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        blur_step(p, typed, typed_pix);
        pixels_sent++;
        gap = pick_gap(src_gaps_on);
        @(negedge clk);
        if (gap > 0)
        begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        pix_if.valid <= 1'b0;
        while (blur_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(input bb3_pkg::side_t v);
        drain_results();
        repeat (SETTLE) @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        set_side(v);
        cfg_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic flag_result(input string why, input bb3_pkg::res_item_t want,
                               input bb3_pkg::res_item_t got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display({"%s: expected row %0d col %0d pix %08h done %0b,",
                      " got row %0d col %0d pix %08h done %0b"},
                     why, want.out_row, want.out_col, want.pixel_out, want.frame_done,
                     got.out_row, got.out_col, got.pixel_out, got.frame_done);
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            sink_ready <= 1'b1;
            stall_left <= pick_gap(sink_stalls_on);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (res_if.data.frame_done)
                frames_seen++;
            if (blur_q.size() == 0)
                flag_result("Unexpected transfer", '0, res_if.data);
            else if (res_if.data.out_row !== blur_q[0].out_row
                     || res_if.data.out_col !== blur_q[0].out_col
                     || res_if.data.pixel_out !== blur_q[0].pixel_out
                     || res_if.data.frame_done !== blur_q[0].frame_done)
                flag_result("Mismatch", blur_q.pop_front(), res_if.data);
            else
                void'(blur_q.pop_front());
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout with %0d results outstanding.", blur_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        int i, n, side, total, pause_at, phase, random_pix;
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        set_side(bb3_pkg::side_t'(bb3_pkg::DEF_SIDE));
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
                cfg_write(bb3_pkg::side_t'(DIRECTED[i].value));
            else
                send_pixel(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].want_pix);
        end

        cfg_write(bb3_pkg::side_t'(8191));
        for (i = 0; i < 5; i++)
            send_pixel(rand_pixel(), 1'b0, '0);
        cfg_write(bb3_pkg::side_t'(SIDE_MAX));
        for (i = 0; i < 5; i++)
            send_pixel(rand_pixel(), 1'b0, '0);

        phase = 0;
        random_pix = 0;
        while (random_pix < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 8)
                side = $urandom_range(0, 1);
            else
                side = $urandom_range(2, 7);
            src_gaps_on = ($urandom_range(0, 4) != 0);
            sink_stalls_on = ($urandom_range(0, 4) != 0);
            cfg_write(bb3_pkg::side_t'(side));
            n = clamp_side(bb3_pkg::side_t'(side));
            total = $urandom_range(1, 2) * n * n;
            if ($urandom_range(0, 3) == 0)
                total += $urandom_range(1, n * n - 1);
            if (total > RANDOM_ITEMS - random_pix)
                total = RANDOM_ITEMS - random_pix;
            pause_at = (phase == 0 || $urandom_range(0, 2) == 0)
                       ? $urandom_range(0, total - 1) : -1;
            for (i = 0; i < total; i++)
            begin
                if (i == pause_at)
                    drain_results();
                send_pixel(rand_pixel(), 1'b0, '0);
                random_pix++;
            end
            phase++;
        end

        drain_results();
        repeat (40) @(negedge clk);
        $display("Sent %0d pixels over %0d side settings; %0d results checked, %0d frames done.",
                 pixels_sent, cfg_writes, results_seen, frames_seen);
        $display("Sides covered 0 to 8191 with back-to-back, partial and interrupted frames.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
